### src/twa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twa_pkg: shared definitions for the time window average block
// Field widths, register limits and the layout of one stored slot.
// ----------------------------------------------------------------------------
package twa_pkg;

    // Default number of slots in the sample store.
    localparam int DEFAULT_SLOT_COUNT = 1024;

    // Field widths of the streams and the window register.
    localparam int WINDOW_W    = 10;
    localparam int STAMP_W     = 32;
    localparam int SAMPLE_W    = 32;
    localparam int AVG_W       = 32;
    localparam int COUNT_OUT_W = 11;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 48;

    // Window register limits.
    localparam int MIN_WINDOW  = 60;
    localparam int PASS_LIMIT  = 1;
    localparam int WINDOW_RST  = 60;

    // Largest entry count that the result field can show.
    localparam int COUNT_MAX   = 2047;

    // One slot of the sample store.
    typedef struct packed {
        logic                valid;
        logic [STAMP_W-1:0]  stamp;
        logic [SAMPLE_W-1:0] sample;
    } slot_entry_t;

endpackage

### src/twa_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twa_slot_ram: slot store
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module twa_slot_ram #(
    parameter int DEPTH = twa_pkg::DEFAULT_SLOT_COUNT
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  twa_pkg::slot_entry_t      wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output twa_pkg::slot_entry_t      rd_data
);
    import twa_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/twa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twa_div: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twa_div #(
    parameter int DIVIDEND_W = 42,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  active_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W:0]    rem_shift;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        if (rem_shift >= {1'b0, divisor_reg}) begin
            rem_next = DIVISOR_W'(rem_shift - {1'b0, divisor_reg});
            quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
        end else begin
            rem_next = rem_shift[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
        end
    end

    // Control of the step sequence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end else if (active_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIVIDEND_W - 1)) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (active_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;

endmodule

### src/time_window_average_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_average_top: moving average over a window of whole seconds
// Stores timestamped samples in slots and averages those inside the window.
// ----------------------------------------------------------------------------
// Usage
//   The input stream carries one beat per sample: timestamp in tdata bits
//   31:0 and the signed Q16.16 sample in bits 63:32. The result stream
//   carries the average in bits 31:0 and the entry count in bits 42:32.
//   The user must write the window register through cfg_wr_en and
//   cfg_wr_data only while the block is idle; the block does not enforce
//   this. 0 or 1 selects passthrough, 2 to 59 are stored as 60. In
//   passthrough the sample is copied to the output register.
//   Otherwise the beat is written to its slot, the store is walked and
//   the average is divided out: the slot index is the low timestamp bits
//   (SLOT_COUNT is a power of two), the walk reads every slot once through
//   the single read port, and the serial divider then forms the average
//   one bit a cycle. The next beat is taken only once the result of the
//   last one has gone to the output register. After reset every slot is
//   cleared while s_tready stays low; configuration writes are still taken.
//   The result sits in an output register, so a stalled receiver holds
//   m_tdata steady, and the next item may be accepted meanwhile; its result
//   waits until the register is free, with s_tready low until then.
// ----------------------------------------------------------------------------
module time_window_average_top #(
    parameter int SLOT_COUNT = twa_pkg::DEFAULT_SLOT_COUNT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [twa_pkg::WINDOW_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: timestamp[31:0], sample[31:0].
    input  logic [twa_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: average[31:0], entry_count[10:0], zero padding.
    output logic [twa_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import twa_pkg::*;

    localparam int IDX_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SUM_W     = SAMPLE_W + IDX_W;
    localparam int CNT_EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
    localparam int PAD_W     = OUT_DATA_W - AVG_W - COUNT_OUT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PASS,
        ST_WRITE,
        ST_WALK,
        ST_AVG,
        ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [WINDOW_W-1:0]      window_reg, window_next;
    logic [STAMP_W-1:0]       stamp_reg, stamp_next;
    logic [SAMPLE_W-1:0]      sample_reg, sample_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         addr_reg, addr_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]         rd_addr_reg, rd_addr_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     neg_reg, neg_next;
    logic [AVG_W-1:0]         res_reg, res_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [AVG_W-1:0]         m_avg_reg, m_avg_next;
    logic [COUNT_OUT_W-1:0]   m_cnt_reg, m_cnt_next;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    slot_entry_t              mem_wdata;
    logic                     mem_re;
    logic [IDX_W-1:0]         mem_raddr;
    slot_entry_t              mem_rdata;

    logic                     div_start;
    logic [SUM_W-1:0]         div_dividend;
    logic [CNT_W-1:0]         div_divisor;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quo;

    logic                     out_free;
    logic [WINDOW_W-1:0]      cfg_window;
    logic [SUM_W-1:0]         sum_mag;
    logic [SUM_W-1:0]         quo_signed;
    logic [CNT_EXT_W-1:0]     count_ext;
    logic [COUNT_OUT_W-1:0]   count_sat;
    logic                     stale;

    // Slot store and the serial divider for the average.
    twa_slot_ram #(
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    twa_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo)
    );

    // Window register write: short windows are raised to the minimum.
    always_comb begin
        cfg_window = cfg_wr_data;
        if (cfg_wr_data > WINDOW_W'(PASS_LIMIT) && cfg_wr_data < WINDOW_W'(MIN_WINDOW)) begin
            cfg_window = WINDOW_W'(MIN_WINDOW);
        end
    end

    // Helpers for the walk and the result.
    always_comb begin
        out_free   = !m_tvalid_reg || m_tready;
        sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        quo_signed = neg_reg ? SUM_W'(-div_quo) : div_quo;
        count_ext  = CNT_EXT_W'(count_reg);
        count_sat  = (count_ext > CNT_EXT_W'(COUNT_MAX)) ? COUNT_OUT_W'(COUNT_MAX)
                                                        : count_ext[COUNT_OUT_W-1:0];
        stale      = ({1'b0, mem_rdata.stamp} + (STAMP_W + 1)'(window_reg))
                     < {1'b0, stamp_reg};
    end

    // Sequencer: clearing pass, passthrough, slot update, walk, divide, output.
    always_comb begin
        state_next    = state_reg;
        window_next   = cfg_wr_en ? cfg_window : window_reg;
        stamp_next    = stamp_reg;
        sample_next   = sample_reg;
        idx_next      = idx_reg;
        addr_next     = addr_reg;
        rd_pend_next  = rd_pend_reg;
        rd_addr_next  = rd_addr_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        neg_next      = neg_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_avg_next    = m_avg_reg;
        m_cnt_next    = m_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = addr_reg[IDX_W-1:0];
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg[IDX_W-1:0];
                if (addr_reg == CNT_W'(SLOT_COUNT - 1)) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    stamp_next  = s_tdata[STAMP_W-1:0];
                    sample_next = s_tdata[STAMP_W+SAMPLE_W-1:STAMP_W];
                    if (window_reg <= WINDOW_W'(PASS_LIMIT)) begin
                        state_next = ST_PASS;
                    end else begin
                        // The slot index is the timestamp modulo the slot count.
                        idx_next   = s_tdata[IDX_W-1:0];
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_PASS: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_avg_next    = sample_reg;
                    m_cnt_next    = COUNT_OUT_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            ST_WRITE: begin
                mem_we           = 1'b1;
                mem_waddr        = idx_reg;
                mem_wdata.valid  = 1'b1;
                mem_wdata.stamp  = stamp_reg;
                mem_wdata.sample = sample_reg;
                addr_next        = '0;
                rd_pend_next     = 1'b0;
                sum_next         = '0;
                count_next       = '0;
                state_next       = ST_WALK;
            end
            ST_WALK: begin
                // Issue the read of the next slot.
                if (addr_reg < CNT_W'(SLOT_COUNT)) begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_addr_next = addr_reg[IDX_W-1:0];
                    addr_next    = addr_reg + CNT_W'(1);
                end else begin
                    rd_pend_next = 1'b0;
                end
                // Retire stale slots and accumulate the rest.
                if (rd_pend_reg && mem_rdata.valid) begin
                    if (stale) begin
                        mem_we          = 1'b1;
                        mem_waddr       = rd_addr_reg;
                        mem_wdata       = mem_rdata;
                        mem_wdata.valid = 1'b0;
                    end else begin
                        sum_next   = sum_reg + SUM_W'($signed(mem_rdata.sample));
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                // All slots seen: divide the magnitude of the sum by the count.
                if (!rd_pend_reg && addr_reg == CNT_W'(SLOT_COUNT)) begin
                    div_start    = 1'b1;
                    div_dividend = sum_mag;
                    div_divisor  = count_reg;
                    neg_next     = sum_reg[SUM_W-1];
                    state_next   = ST_AVG;
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    res_next   = quo_signed[AVG_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_avg_next    = res_reg;
                    m_cnt_next    = count_sat;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            window_reg   <= WINDOW_W'(WINDOW_RST);
            addr_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            addr_reg     <= addr_next;
            rd_pend_reg  <= rd_pend_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        stamp_reg   <= stamp_next;
        sample_reg  <= sample_next;
        idx_reg     <= idx_next;
        rd_addr_reg <= rd_addr_next;
        sum_reg     <= sum_next;
        neg_reg     <= neg_next;
        res_reg     <= res_next;
        m_avg_reg   <= m_avg_next;
        m_cnt_reg   <= m_cnt_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {PAD_W'(0), m_cnt_reg, m_avg_reg};

    // The slot index is taken straight from the low timestamp bits.
    a_slot_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        (SLOT_COUNT & (SLOT_COUNT - 1)) == 0)
        else $error("slot count is not a power of two");

    // The count of slots in the window can never pass the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOT_COUNT))
        else $error("slot count above store depth");

    // A write-back during the walk never hits the slot being read.
    a_walk_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("walk write-back collides with read");

    // The new sample is always in the window, so the divisor is never zero.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && div_start) |-> (count_reg != '0))
        else $error("average started with zero count");

    // A fresh result always reports at least one entry.
    a_out_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (m_cnt_reg != '0))
        else $error("result with zero entry count");

    // No beat is taken as the clearing pass begins after reset.
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input accepted during clearing pass");

endmodule
